FILE: sv/lsc_pkg.sv
// lsc_pkg: shared constants and structs for the LRU slot cache.
// Used by lsc_tag_store and lru_slot_cache_core; no dependencies.
package lsc_pkg;

   localparam int unsigned CAPACITY_DEF = 16;
   localparam int unsigned KEY_BITS_DEF = 32;

   // Fixed port widths
   localparam int unsigned ID_W   = 32;
   localparam int unsigned SLOT_W = 4;
   localparam int unsigned CFG_W  = 5;

   localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RESET = CFG_W'(16);

   // One request presented to the tag store in the processing cycle
   typedef struct packed {
      logic go;     // request is processed this cycle
      logic alloc;  // allocate on miss
   } lsc_cmd_type;

   // Outcome of one request, captured into the result register
   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              ev_valid;
      logic [ID_W-1:0]   ev_id;
   } lsc_result_type;

endpackage

FILE: sv/lsc_tag_store.sv
// lsc_tag_store: fully associative tag store with true-LRU ranks and fill count.
// Depends on lsc_pkg. Lookup is combinational, state updates on cmd.go.
module lsc_tag_store #(
   parameter int unsigned CAPACITY = lsc_pkg::CAPACITY_DEF,
   parameter int unsigned KEY_BITS = lsc_pkg::KEY_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lsc_pkg::lsc_cmd_type       cmd,
   input  logic [KEY_BITS-1:0]        key,
   input  logic [lsc_pkg::CFG_W-1:0]  active_slots,
   output lsc_pkg::lsc_result_type    result
);
   import lsc_pkg::*;

   localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

   logic [CAPACITY-1:0]             valid_ff, valid_in;
   logic [KEY_BITS-1:0]             key_ff  [CAPACITY];
   logic [KEY_BITS-1:0]             key_in  [CAPACITY];
   logic [IDX_W-1:0]                rank_ff [CAPACITY];
   logic [IDX_W-1:0]                rank_in [CAPACITY];
   logic [FILL_W-1:0]               fill_ff, fill_in;

   logic [CAPACITY-1:0] match, victim, new_sel, touch_sel;
   logic                hit, new_ok, install, fill_new, evict, update;
   logic [IDX_W-1:0]    hit_idx, hit_rank, vict_idx, last_rank, touch_rank, slot_idx;
   logic [KEY_BITS-1:0] vict_key;

   // Valid ranks are always a permutation of 0..fill-1, so the LRU entry
   // is simply the one ranked fill-1.
   assign last_rank = IDX_W'(fill_ff - FILL_W'(1));

   always_comb begin
      hit_idx  = '0;
      hit_rank = '0;
      vict_idx = '0;
      vict_key = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match[i]   = valid_ff[i] && (key_ff[i] == key);
         victim[i]  = valid_ff[i] && (rank_ff[i] == last_rank);
         new_sel[i] = (fill_ff == FILL_W'(i));
         if (match[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
         if (victim[i]) begin
            vict_idx = vict_idx | IDX_W'(i);
            vict_key = vict_key | key_ff[i];
         end
      end
   end

   assign hit = |match;

   // Free slot left: fill below capacity and below the clamped active count
   assign new_ok = (fill_ff < FILL_W'(CAPACITY)) &&
                   ((CMP_W'(fill_ff) < CMP_W'(active_slots)) ||
                    ((active_slots == '0) && (fill_ff == '0)));

   assign install  = cmd.go && cmd.alloc && !hit;
   assign fill_new = install && new_ok;
   assign evict    = install && !new_ok;
   assign update   = cmd.go && (hit || cmd.alloc);

   // Hit, fresh fill and eviction are all a "touch" of one slot
   assign touch_sel  = hit ? match : (new_ok ? new_sel : victim);
   assign touch_rank = hit ? hit_rank : (new_ok ? IDX_W'(fill_ff) : last_rank);
   assign slot_idx   = hit ? hit_idx  : (new_ok ? IDX_W'(fill_ff) : vict_idx);

   always_comb begin
      result.hit      = hit;
      result.slot     = (hit || cmd.alloc) ? SLOT_W'(slot_idx) : '0;
      result.ev_valid = evict;
      result.ev_id    = evict ? ID_W'(vict_key) : '0;
   end

   always_comb begin
      valid_in = valid_ff;
      fill_in  = fill_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         key_in[i]  = key_ff[i];
         rank_in[i] = rank_ff[i];
         if (update) begin
            if (touch_sel[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < touch_rank)) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
         if (install && touch_sel[i]) begin
            valid_in[i] = 1'b1;
            key_in[i]   = key;
         end
      end
      if (fill_new) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= '0;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         fill_ff  <= fill_in;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // Keys are payload: only read behind a valid bit
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         key_ff[i] <= key_in[i];
      end
   end

endmodule

FILE: sv/lru_slot_cache_core.sv
// lru_slot_cache_core: top level of the fully associative true-LRU slot cache.
// Depends on lsc_pkg and lsc_tag_store; checked by lsc_checker (bound).
//
// Each request beat names a block (req_block_id) and is a lookup
// (req_kind = 0) or an allocate (req_kind = 1). A beat is taken into an
// input register; when the result register is free, its key is compared
// against every resident tag at once, the LRU ranks are updated and the
// outcome is captured in the result register. One request is taken per
// cycle while the result side is not stalled. The rate is set by the tag
// compare and rank update, since each request sees the recency order left
// by the one before it. While a result waits under rsp_stall, one more
// request can sit in the input register; req_stall rises only when both
// are full. Allocates fill slots 0, 1, 2, ... up to the active slot count,
// then evict the LRU block and report its id. The active slot count must
// be written on the csr_ channel only while the block is idle; the block
// itself does not enforce this. 0 acts as 1, values above CAPACITY act as
// CAPACITY, and lowering it below the current fill keeps resident blocks.
// Reset is synchronous, with no clearing pass.
module lru_slot_cache_core #(
   parameter int unsigned CAPACITY = lsc_pkg::CAPACITY_DEF,
   parameter int unsigned KEY_BITS = lsc_pkg::KEY_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_kind,
   input  logic [lsc_pkg::ID_W-1:0]    req_block_id,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_hit,
   output logic [lsc_pkg::SLOT_W-1:0]  rsp_slot,
   output logic                        rsp_evicted_valid,
   output logic [lsc_pkg::ID_W-1:0]    rsp_evicted_block_id,
   // configuration write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lsc_pkg::CFG_W-1:0]   csr_active_slots
);
   import lsc_pkg::*;

   // input register
   logic                in_valid_ff, in_valid_in;
   logic                in_kind_ff;
   logic [KEY_BITS-1:0] in_key_ff;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   lsc_result_type  rsp_ff;

   logic [CFG_W-1:0] active_ff;

   lsc_cmd_type    cmd;
   lsc_result_type result;

   logic rsp_free, process, req_take;

   // Result register can load when empty or being drained this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && rsp_free;
   assign req_stall = in_valid_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;

   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !process);
   assign rsp_valid_in = process || (rsp_valid_ff && rsp_stall);

   assign cmd.go    = process;
   assign cmd.alloc = in_kind_ff;

   lsc_tag_store #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_tag_store (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .key          (in_key_ff),
      .active_slots (active_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= ACTIVE_SLOTS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            active_ff <= csr_active_slots;
         end
      end
   end

   // Payload registers; key truncated or zero-extended to KEY_BITS
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_kind;
         in_key_ff  <= KEY_BITS'(req_block_id);
      end
      if (process) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_ff.hit;
   assign rsp_slot             = rsp_ff.slot;
   assign rsp_evicted_valid    = rsp_ff.ev_valid;
   assign rsp_evicted_block_id = rsp_ff.ev_id;

endmodule

FILE: sv/lsc_checker.sv
// lsc_checker: port-level assertions for lru_slot_cache_core, plus its bind.
// Depends on lsc_pkg for port widths.
module lsc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_hit,
   input logic [lsc_pkg::SLOT_W-1:0]  rsp_slot,
   input logic                        rsp_evicted_valid,
   input logic [lsc_pkg::ID_W-1:0]    rsp_evicted_block_id
);
   import lsc_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_slot)
         && $stable(rsp_evicted_valid) && $stable(rsp_evicted_block_id))
      else $error("stalled result beat changed");

   // a request taken, then a free result side, gives a registered result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("request beat produced no result");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_evicted_valid)
      else $error("hit reported an eviction");

   a_evict_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> rsp_evicted_block_id == '0)
      else $error("evicted id nonzero without eviction");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind lru_slot_cache_core lsc_checker u_lsc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_hit              (rsp_hit),
   .rsp_slot             (rsp_slot),
   .rsp_evicted_valid    (rsp_evicted_valid),
   .rsp_evicted_block_id (rsp_evicted_block_id)
);

FILE: tb/lru_slot_cache_core_tb.sv
// lru_slot_cache_core_tb: self-checking testbench for the LRU slot cache core.
// Depends on lsc_pkg and lru_slot_cache_core. A built-in LRU mirror predicts
// every result beat. Stimulus is a directed part followed by random phases.
module lru_slot_cache_core_tb;
   import lsc_pkg::*;

   localparam int unsigned SLOTS        = CAPACITY_DEF;
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned HOLD_CYCLES  = 64;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned PHASES       = 8;

   typedef enum logic {
      KIND_LOOKUP   = 1'b0,
      KIND_ALLOCATE = 1'b1
   } req_kind_e;

   // Mirror of the tag store, recency ranks and fill pointer.
   class lru_cache_mirror;
      bit                   slot_valid [SLOTS];
      logic [ID_W-1:0]      slot_key [SLOTS];
      bit [SLOT_W-1:0]      slot_rank [SLOTS];
      int unsigned          filled;
      logic [CFG_W-1:0]     active_slots;
      int unsigned          mismatches;
      lsc_result_type       expected_outcomes [$];

      function new();
         foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_rank[i]  = '0;
         end
         filled       = 0;
         active_slots = ACTIVE_SLOTS_RESET;
         mismatches   = 0;
      endfunction

      function int unsigned pending();
         return expected_outcomes.size();
      endfunction

      function void set_active_slots(logic [CFG_W-1:0] value);
         active_slots = value;
      endfunction

      // Make slot s most recent; valid entries more recent than it age by one.
      function void promote(int unsigned s);
         bit [SLOT_W-1:0] r;
         r = slot_rank[s];
         for (int unsigned i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && i != s && slot_rank[i] < r)
               slot_rank[i]++;
         end
         slot_rank[s] = '0;
      endfunction

      function void note_request(req_kind_e kind, logic [ID_W-1:0] id);
         lsc_result_type res;
         int             hit_at;
         int unsigned    eff;
         int unsigned    victim;
         bit             any;
         res    = '0;
         hit_at = -1;
         for (int unsigned i = 0; i < SLOTS; i++) begin
            if (hit_at < 0 && slot_valid[i] && slot_key[i] == id)
               hit_at = i;
         end
         if (hit_at >= 0) begin
            promote(hit_at);
            res.hit  = 1'b1;
            res.slot = SLOT_W'(hit_at);
         end else if (kind == KIND_ALLOCATE) begin
            // zero acts as one, anything above capacity saturates
            eff = (active_slots == 0) ? 1 :
                  (active_slots > SLOTS) ? SLOTS : active_slots;
            if (filled < eff) begin
               for (int unsigned i = 0; i < SLOTS; i++) begin
                  if (slot_valid[i])
                     slot_rank[i]++;
               end
               slot_valid[filled] = 1'b1;
               slot_key[filled]   = id;
               slot_rank[filled]  = '0;
               res.slot           = SLOT_W'(filled);
               filled++;
            end else begin
               // oldest valid entry; ties go to the lowest slot
               victim = 0;
               any    = 1'b0;
               for (int unsigned i = 0; i < SLOTS; i++) begin
                  if (slot_valid[i] && (!any || slot_rank[i] > slot_rank[victim])) begin
                     victim = i;
                     any    = 1'b1;
                  end
               end
               res.slot = SLOT_W'(victim);
               if (any) begin
                  res.ev_valid = 1'b1;
                  res.ev_id    = slot_key[victim];
                  promote(victim);
               end else begin
                  slot_rank[victim] = '0;
               end
               slot_valid[victim] = 1'b1;
               slot_key[victim]   = id;
            end
         end
         expected_outcomes = {expected_outcomes, res};
      endfunction

      function void check_result(logic hit, logic [SLOT_W-1:0] slot, logic ev_valid,
                                 logic [ID_W-1:0] ev_id);
         lsc_result_type want;
         if (expected_outcomes.size() == 0) begin
            $error("result beat with no request outstanding");
            mismatches++;
            return;
         end
         want = expected_outcomes.pop_front();
         if (hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit);
            mismatches++;
         end
         if (slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, slot);
            mismatches++;
         end
         if (ev_valid !== want.ev_valid) begin
            $error("evicted_valid: expected %0d, got %0d", want.ev_valid, ev_valid);
            mismatches++;
         end
         if (ev_id !== want.ev_id) begin
            $error("evicted_block_id: expected %h, got %h", want.ev_id, ev_id);
            mismatches++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_kind = KIND_LOOKUP;
   logic [ID_W-1:0]    req_block_id = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_hit;
   logic [SLOT_W-1:0]  rsp_slot;
   logic               rsp_evicted_valid;
   logic [ID_W-1:0]    rsp_evicted_block_id;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CFG_W-1:0]   csr_active_slots = '0;

   lru_cache_mirror    mirror = new();
   int unsigned        req_idle_pct = 0;
   int unsigned        rsp_idle_pct = 0;
   bit                 hold_rsp = 1'b0;
   int unsigned        quiet_cycles = 0;

   lru_slot_cache_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_block_id         (req_block_id),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_hit              (rsp_hit),
      .rsp_slot             (rsp_slot),
      .rsp_evicted_valid    (rsp_evicted_valid),
      .rsp_evicted_block_id (rsp_evicted_block_id),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_active_slots     (csr_active_slots)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Result side: random stall, or a long hold-off on request so the
   // input register backs up and req_stall rises.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
         end
      end
   end

   // Beat monitor and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            mirror.note_request(req_kind_e'(req_kind), req_block_id);
         if (rsp_valid && !rsp_stall)
            mirror.check_result(rsp_hit, rsp_slot, rsp_evicted_valid, rsp_evicted_block_id);
         if (csr_valid && csr_ready)
            mirror.set_active_slots(csr_active_slots);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // One beat, then idle cycle by cycle at the sender's idle rate.
   task automatic send_request(input req_kind_e kind, input logic [ID_W-1:0] id);
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_block_id <= id;
      do @(posedge clock); while (req_stall);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Let every outstanding result drain, then the pipeline settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_active_slots(input logic [CFG_W-1:0] value);
      drain_results();
      csr_valid        <= 1'b1;
      csr_active_slots <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_phase(input logic [CFG_W-1:0] slots, input int unsigned count,
                                   input bit squeeze);
      int unsigned     pool_n;
      logic [ID_W-1:0] base;
      logic [ID_W-1:0] id;
      req_kind_e       kind;
      write_active_slots(slots);
      // id pool a bit larger than the slot count: plenty of hits and evictions
      pool_n = int'(slots) + int'(slots) / 2 + 2;
      base   = $urandom;
      for (int unsigned n = 0; n < count; n++) begin
         if (squeeze && n == count / 3)
            hold_rsp = 1'b1;
         if ($urandom_range(0, 9) == 0)
            id = $urandom;
         else
            id = base + $urandom_range(0, pool_n - 1);
         kind = ($urandom_range(0, 99) < 55) ? KIND_ALLOCATE : KIND_LOOKUP;
         send_request(kind, id);
      end
   endtask

   int unsigned phase_slots [PHASES] = '{5, 1, 8, 16, 0, 31, 12, 16};

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 16;
      rsp_idle_pct = 53;

      // Directed: reset slot count, empty cache, id extremes.
      send_request(KIND_LOOKUP,   32'h0000_0000);   // miss on empty cache
      send_request(KIND_ALLOCATE, 32'h0000_0000);
      send_request(KIND_ALLOCATE, 32'hFFFF_FFFF);
      send_request(KIND_ALLOCATE, 32'h0000_0000);   // allocate of resident block
      send_request(KIND_LOOKUP,   32'hFFFF_FFFF);
      send_request(KIND_LOOKUP,   32'h5A5A_5A5A);   // lookup miss
      // two slots, already full: allocate evicts the LRU block
      write_active_slots(CFG_W'(2));
      send_request(KIND_ALLOCATE, 32'hA5A5_A5A5);
      // zero acts as one; blocks above the limit stay resident
      write_active_slots(CFG_W'(0));
      send_request(KIND_LOOKUP,   32'hFFFF_FFFF);
      send_request(KIND_ALLOCATE, 32'h8000_0000);
      send_request(KIND_ALLOCATE, 32'h0000_0001);
      send_request(KIND_LOOKUP,   32'hA5A5_A5A5);
      // above capacity saturates; fill resumes at the next unused slot
      write_active_slots(CFG_W'(31));
      send_request(KIND_ALLOCATE, 32'h7FFF_FFFF);
      send_request(KIND_ALLOCATE, 32'h0000_0001);
      send_request(KIND_ALLOCATE, 32'hDEAD_BEEF);
      send_request(KIND_LOOKUP,   32'h8000_0000);
      send_request(KIND_LOOKUP,   32'h7FFF_FFFF);

      for (int unsigned p = 0; p < PHASES; p++) begin
         if (p < 3) begin
            req_idle_pct = 16;
            rsp_idle_pct = 53;
         end else if (p < 6) begin
            req_idle_pct = 53;
            rsp_idle_pct = 16;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         run_random_phase(CFG_W'(phase_slots[p]), 100, (p == 1 || p == 6));
      end

      drain_results();
      if (mirror.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
